@@ design/nvst_pkg.sv @@
// ----------------------------------------------------------------------------
// nvst_pkg
// shared types and constants for the nearest value sorted table
// ----------------------------------------------------------------------------
package nvst_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_HIT   = 3'd3;
  localparam logic [2:0] ST_NEAR  = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;

  typedef struct packed {
    logic               command;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_value;
  } out_word_t;

endpackage

@@ design/nearest_value_sorted_table.sv @@
// ----------------------------------------------------------------------------
// nearest_value_sorted_table
// sorted table of distinct signed values with insert and nearest-value query
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; exactly one result word
// follows, shown on out_word for one cycle with out_valid high, and the
// receiver cannot stall it. Entries sit in ascending order in a single
// synchronous memory with one read and one write port. An item runs a binary
// search of at most ceil(log2(n+1)) steps for n stored entries (at most 9),
// each a memory read and a compare, and an insert then moves every entry at
// or above its slot up by one slot, top end first, before writing the value.
// Ties in a query go to the smaller neighbor; an empty table reports status
// empty.
// ----------------------------------------------------------------------------
module nearest_value_sorted_table
  import nvst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_PROBE = 4'd3;
  localparam logic [3:0] S_EQ    = 4'd4;
  localparam logic [3:0] S_NCMP  = 4'd5;
  localparam logic [3:0] S_SHRD  = 4'd6;
  localparam logic [3:0] S_SHWR  = 4'd7;
  localparam logic [3:0] S_PUT   = 4'd8;

  logic signed [31:0] mem [CAPACITY];

  logic [3:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic [CNT_W-1:0]   sh_r, sh_nxt;
  logic [IDX_W-1:0]   mid_r, mid_nxt;
  logic               cmd_r, cmd_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [31:0] above_r, above_nxt;
  logic signed [31:0] rd_data_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [31:0] wr_data;

  logic [CNT_W-1:0]   mid_full;
  logic signed [32:0] d_low, d_high;
  logic               eq;

  function automatic logic [IDX_W-1:0] lo_nxt_below(input logic [CNT_W-1:0] idx);
    logic [CNT_W-1:0] dec;
    dec = idx - CNT_W'(1);
    return dec[IDX_W-1:0];
  endfunction

  assign mid_full = lo_r + ((hi_r - lo_r) >> 1);
  assign eq       = (lo_r < count_r) && (rd_data_r == val_r);
  // distances one bit wider than the values so they cannot wrap
  assign d_low    = {val_r[31], val_r} - {rd_data_r[31], rd_data_r};
  assign d_high   = {above_r[31], above_r} - {val_r[31], val_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    sh_nxt        = sh_r;
    mid_nxt       = mid_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    above_nxt     = above_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    rd_en         = 1'b0;
    rd_addr       = mid_full[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = sh_r[IDX_W-1:0];
    wr_data       = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_word.command;
          val_nxt   = in_word.value;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = mid_full[IDX_W-1:0];
          mid_nxt   = mid_full[IDX_W-1:0];
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_CMP: begin
        if (rd_data_r < val_r) begin
          lo_nxt = {1'b0, mid_r} + CNT_W'(1);
        end else begin
          hi_nxt = {1'b0, mid_r};
        end
        state_nxt = S_SRCH;
      end
      S_PROBE: begin
        // first entry not below the value, if there is one
        if (lo_r < count_r) begin
          rd_en   = 1'b1;
          rd_addr = lo_r[IDX_W-1:0];
        end
        state_nxt = S_EQ;
      end
      S_EQ: begin
        above_nxt = rd_data_r;
        if (cmd_r == CMD_INSERT) begin
          if (eq) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: ST_DUP, result_value: '0};
            state_nxt     = S_IDLE;
          end else if (count_r == CNT_W'(CAPACITY)) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: ST_FULL, result_value: '0};
            state_nxt     = S_IDLE;
          end else begin
            sh_nxt    = count_r;
            state_nxt = (count_r == lo_r) ? S_PUT : S_SHRD;
          end
        end else begin
          if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: ST_EMPTY, result_value: '0};
            state_nxt     = S_IDLE;
          end else if (eq) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: ST_HIT, result_value: val_r};
            state_nxt     = S_IDLE;
          end else if (lo_r == '0) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: ST_NEAR, result_value: rd_data_r};
            state_nxt     = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = lo_nxt_below(lo_r);
            state_nxt = S_NCMP;
          end
        end
      end
      S_NCMP: begin
        out_valid_nxt = 1'b1;
        out_word_nxt.status = ST_NEAR;
        if (lo_r >= count_r || d_low <= d_high) begin
          out_word_nxt.result_value = rd_data_r;
        end else begin
          out_word_nxt.result_value = above_r;
        end
        state_nxt = S_IDLE;
      end
      S_SHRD: begin
        rd_en     = 1'b1;
        rd_addr   = lo_nxt_below(sh_r);
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        // move one entry up by one slot, top end first
        wr_en     = 1'b1;
        wr_addr   = sh_r[IDX_W-1:0];
        wr_data   = rd_data_r;
        sh_nxt    = sh_r - CNT_W'(1);
        state_nxt = ((sh_r - CNT_W'(1)) == lo_r) ? S_PUT : S_SHRD;
      end
      S_PUT: begin
        wr_en         = 1'b1;
        wr_addr       = lo_r[IDX_W-1:0];
        wr_data       = val_r;
        count_nxt     = count_r + CNT_W'(1);
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{status: ST_ADDED, result_value: '0};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    sh_r       <= sh_nxt;
    mid_r      <= mid_nxt;
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    above_r    <= above_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ design/nvst_checker.sv @@
// ----------------------------------------------------------------------------
// nvst_checker
// port-level checks for the nearest value sorted table
// ----------------------------------------------------------------------------
module nvst_checker
  import nvst_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);

  // an accepted word makes the block busy, and it stays busy until its result is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting a word");

  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result shown outside the end of an item");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result words in a row");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status <= ST_EMPTY)
    else $error("status code out of range");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_HIT && out_word.status != ST_NEAR
      |-> out_word.result_value == '0)
    else $error("nonzero value with a non-query status");

endmodule

bind nearest_value_sorted_table nvst_checker u_nvst_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the nearest value sorted table
// ----------------------------------------------------------------------------
// Directed words cover the empty table, duplicates, both value extremes,
// queries outside the stored range and tied distances. Random inserts and
// queries then fill the table to capacity and keep querying it. A bench-side
// copy of the sorted table predicts every result word, and the monitor checks
// each one against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import nvst_pkg::*;

  localparam int RANDOM_WORDS  = 950;
  localparam int SETTLE_CYCLES = 600;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  in_word_t           queued_cmds[$];
  out_word_t          pending_answers[$];
  logic signed [31:0] table_copy[$];
  logic signed [31:0] inserted_vals[$];

  int planned_items = 0;
  int items_taken = 0;
  int errors = 0;
  int status_seen[6];

  nearest_value_sorted_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // applies one word to the bench copy of the table and returns its answer
  function automatic out_word_t sorted_table_step(in_word_t w);
    out_word_t          r;
    logic signed [31:0] v;
    int                 pos;
    int                 n;
    longint             d_lo;
    longint             d_hi;
    v = $signed(w.value);
    r.status = ST_ADDED;
    r.result_value = '0;
    n = table_copy.size();
    pos = 0;
    while (pos < n && table_copy[pos] < v) pos++;
    if (w.command == CMD_INSERT) begin
      if (pos < n && table_copy[pos] == v) begin
        r.status = ST_DUP;
      end else if (n >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        table_copy.insert(pos, v);
        r.status = ST_ADDED;
      end
    end else begin
      if (n == 0) begin
        r.status = ST_EMPTY;
      end else if (pos < n && table_copy[pos] == v) begin
        r.status = ST_HIT;
        r.result_value = v;
      end else if (pos == 0) begin
        r.status = ST_NEAR;
        r.result_value = table_copy[0];
      end else if (pos >= n) begin
        r.status = ST_NEAR;
        r.result_value = table_copy[n - 1];
      end else begin
        // 64-bit distances, ties go to the lower neighbor
        d_lo = longint'(v) - longint'(table_copy[pos - 1]);
        d_hi = longint'(table_copy[pos]) - longint'(v);
        r.status = ST_NEAR;
        r.result_value = (d_lo <= d_hi) ? table_copy[pos - 1] : table_copy[pos];
      end
    end
    return r;
  endfunction

  function automatic void queue_word(logic cmd, logic signed [31:0] v);
    in_word_t w;
    w.command = cmd;
    w.value = v;
    queued_cmds.insert(queued_cmds.size(), w);
    if (cmd == CMD_INSERT) inserted_vals.insert(inserted_vals.size(), v);
  endfunction

  // driver: holds start until the word is taken, then idles at random
  always @(posedge clk) begin
    logic take;
    logic quiet;
    take = start && !busy;
    quiet = (items_taken >= 300 && items_taken < 450);
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (take) begin
        pending_answers.insert(pending_answers.size(), sorted_table_step(in_word));
        items_taken++;
      end
      if (take || !start) begin
        if (queued_cmds.size() > 0 && (quiet || $urandom_range(0, 99) >= 24)) begin
          start   <= 1'b1;
          in_word <= queued_cmds.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed word must match the oldest prediction
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $error("result word with no prediction waiting: status %0d value %0d",
               out_word.status, $signed(out_word.result_value));
        errors++;
      end else begin
        exp_w = pending_answers.pop_front();
        if (exp_w.status <= ST_EMPTY) status_seen[exp_w.status]++;
        if (out_word.status !== exp_w.status) begin
          $error("status: expected %0d, actual %0d", exp_w.status, out_word.status);
          errors++;
        end
        if (out_word.result_value !== exp_w.result_value) begin
          $error("result_value: expected %0d, actual %0d",
                 $signed(exp_w.result_value), $signed(out_word.result_value));
          errors++;
        end
      end
    end
  end

  initial begin
    int                 r;
    logic               cmd;
    logic signed [31:0] v;
    longint             a;
    longint             b;
    foreach (status_seen[i]) status_seen[i] = 0;

    // directed: empty table, single entry, ties, extremes
    queue_word(CMD_QUERY, 32'sd0);
    queue_word(CMD_QUERY, 32'sh8000_0000);
    queue_word(CMD_QUERY, 32'sh7fff_ffff);
    queue_word(CMD_INSERT, 32'sd0);
    queue_word(CMD_QUERY, 32'sd0);
    queue_word(CMD_INSERT, 32'sd0);
    queue_word(CMD_QUERY, -32'sd5);
    queue_word(CMD_QUERY, 32'sd5);
    queue_word(CMD_INSERT, 32'sd100);
    queue_word(CMD_INSERT, 32'sd200);
    queue_word(CMD_QUERY, 32'sd150);
    queue_word(CMD_QUERY, 32'sd151);
    queue_word(CMD_QUERY, 32'sd1000);
    queue_word(CMD_QUERY, 32'sh8000_0000);
    queue_word(CMD_INSERT, 32'sh7fff_ffff);
    queue_word(CMD_INSERT, 32'sh8000_0000);
    queue_word(CMD_QUERY, 32'sh7fff_ffff);
    queue_word(CMD_QUERY, 32'sh8000_0000);
    queue_word(CMD_QUERY, -32'sd1);
    queue_word(CMD_QUERY, 32'shc000_0000);
    queue_word(CMD_QUERY, 32'sh7fff_fffe);
    queue_word(CMD_INSERT, 32'sh8000_0000);

    // random: enough distinct inserts to fill the table, then keep going full
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      cmd = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_QUERY;
      r = $urandom_range(0, 99);
      v = $urandom;
      if (r < 25 || inserted_vals.size() == 0) begin
        v = $urandom;
      end else if (r < 40) begin
        v = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
      end else if (r < 55) begin
        v = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)]
            + (int'($urandom_range(0, 8)) - 4);
      end else if (r < 70) begin
        // halfway between two stored values gives tied distances
        a = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
        b = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
        a = (a + b) >>> 1;
        v = a[31:0] + $urandom_range(0, 1);
      end else if (r < 82) begin
        // tight cluster, inserts spaced by four and queries by two
        v = (int'($urandom_range(0, 500)) - 250) * ((cmd == CMD_INSERT) ? 4 : 2);
      end else if (r < 90) begin
        v = $urandom_range(0, 1) ? 32'sh8000_0000 + $urandom_range(0, 16)
                                 : 32'sh7fff_ffff - $urandom_range(0, 16);
      end else begin
        v = 32'sd1 <<< $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = ~v;
      end
      queue_word(cmd, v);
    end
    planned_items = queued_cmds.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (items_taken == planned_items);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d words checked, table ended with %0d entries", planned_items,
             table_copy.size());
    $display("added %0d, duplicate %0d, full %0d, hit %0d, nearest %0d, empty %0d",
             status_seen[ST_ADDED], status_seen[ST_DUP], status_seen[ST_FULL],
             status_seen[ST_HIT], status_seen[ST_NEAR], status_seen[ST_EMPTY]);
    if (errors == 0) begin
      $display("PASS nearest_value_sorted_table");
    end else begin
      $display("FAIL nearest_value_sorted_table");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL nearest_value_sorted_table");
    $finish;
  end

endmodule
